@@ src/cslp_pkg.sv @@
// cslp_pkg: shared constants, codes and types of the clock-synced audio looper
// no dependencies; used by the channel interfaces and all looper modules

package cslp_pkg;

   // default geometry of the loop store and the sample word
   localparam int STORE_DEPTH_DEF = 2097152;
   localparam int SAMPLE_BITS_DEF = 24;

   // fixed field widths
   localparam int COUNT_BITS    = 6;
   localparam int TIMEOUT_BITS  = 16;
   localparam int TIME_BITS     = 32;
   localparam int MODE_BITS     = 2;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 16;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_LOOP_LENGTH = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TIMEOUT_MS  = 2'd1;

   // register reset values
   localparam logic [COUNT_BITS-1:0]   LOOP_LENGTH_RST = 6'd16;
   localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_MS_RST  = 16'd1000;

   // looper modes
   localparam logic [MODE_BITS-1:0] MODE_IDLE   = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_ARMED  = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_RECORD = 2'd2;
   localparam logic [MODE_BITS-1:0] MODE_PLAY   = 2'd3;

   // control word handed from the store stage to the output stage
   typedef struct packed {
      logic                  use_store;
      logic [MODE_BITS-1:0]  mode;
      logic [COUNT_BITS-1:0] count;
   } meta_type;

endpackage

@@ src/cslp_chan_if.sv @@
// cslp channel interfaces: frame input, result output and register write port
// depends on cslp_pkg for field widths

interface cslp_req_if #(
   parameter int SAMPLE_BITS = cslp_pkg::SAMPLE_BITS_DEF
);
   logic                             valid;
   logic                             ready;
   logic                             gate;
   logic                             arm;
   logic [cslp_pkg::TIME_BITS-1:0]   time_ms;
   logic signed [SAMPLE_BITS-1:0]    sample_in;

   modport source (output valid, gate, arm, time_ms, sample_in, input ready);
   modport sink   (input valid, gate, arm, time_ms, sample_in, output ready);
endinterface

interface cslp_rsp_if #(
   parameter int SAMPLE_BITS = cslp_pkg::SAMPLE_BITS_DEF
);
   logic                              valid;
   logic                              ready;
   logic signed [SAMPLE_BITS-1:0]     sample_out;
   logic [cslp_pkg::MODE_BITS-1:0]    loop_mode;
   logic [cslp_pkg::COUNT_BITS-1:0]   pulse_number;

   modport source (output valid, sample_out, loop_mode, pulse_number, input ready);
   modport sink   (input valid, sample_out, loop_mode, pulse_number, output ready);
endinterface

interface cslp_csr_if;
   logic                                valid;
   logic                                ready;
   logic [cslp_pkg::CSR_IDX_BITS-1:0]   index;
   logic [cslp_pkg::CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ src/cslp_out_stage.sv @@
// cslp_out_stage: playback mix with saturation and the result output register
// depends on cslp_pkg and cslp_rsp_if

module cslp_out_stage #(
   parameter int SAMPLE_BITS = cslp_pkg::SAMPLE_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  cslp_pkg::meta_type             in_meta,
   input  logic signed [SAMPLE_BITS-1:0]  in_sample,
   input  logic signed [SAMPLE_BITS-1:0]  in_stored,
   cslp_rsp_if.source                     rsp
);

   localparam logic signed [SAMPLE_BITS-1:0] SAT_HI = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAT_LO = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic                          valid_ff, valid_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in_w;
   logic [cslp_pkg::MODE_BITS-1:0]  mode_ff;
   logic [cslp_pkg::COUNT_BITS-1:0] count_ff;
   logic signed [SAMPLE_BITS:0]   sum;
   logic signed [SAMPLE_BITS-1:0] addend;
   logic                          take;

   // stage takes a word when the output register is empty or drains
   assign in_ready = !valid_ff || rsp.ready;
   assign take     = in_valid && in_ready;

   // input plus stored sample (when use_store is set), clipped to the sample range
   always_comb begin
      addend = in_meta.use_store ? in_stored : '0;
      sum    = {in_sample[SAMPLE_BITS-1], in_sample} + {addend[SAMPLE_BITS-1], addend};
      if (sum[SAMPLE_BITS] != sum[SAMPLE_BITS-1]) begin
         sample_in_w = sum[SAMPLE_BITS] ? SAT_LO : SAT_HI;
      end else begin
         sample_in_w = sum[SAMPLE_BITS-1:0];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         sample_ff <= sample_in_w;
         mode_ff   <= in_meta.mode;
         count_ff  <= in_meta.count;
      end
   end

   assign rsp.valid        = valid_ff;
   assign rsp.sample_out   = sample_ff;
   assign rsp.loop_mode    = mode_ff;
   assign rsp.pulse_number = count_ff;

endmodule

@@ src/clock_synced_audio_looper_top.sv @@
// clock_synced_audio_looper_top: pulse counting, mode control and the loop store
// depends on cslp_pkg, cslp_chan_if and cslp_out_stage
//
//  channel  | dir | payload                               | accepted when
//  req_bus  | in  | gate, arm, time_ms, sample_in         | valid && ready
//  rsp_bus  | out | sample_out, loop_mode, pulse_number   | valid && ready
//  csr_bus  | in  | index, data (register write)          | valid && ready
//
// One frame per cycle while the result output does not stall; an accepted
// frame's result passes the store read stage, then the output register.
// The pulse, position and mode update of each frame is combinational; the
// store has one write port and one registered read port.
// Reset is synchronous; the store needs no clearing pass: a fill count marks
// the recorded prefix, and entries past it read as zero.
// A stalled result holds in the output register while one more frame waits in
// the store read stage; register writes are always taken.

module clock_synced_audio_looper_top #(
   parameter int STORE_DEPTH = cslp_pkg::STORE_DEPTH_DEF,
   parameter int SAMPLE_BITS = cslp_pkg::SAMPLE_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   cslp_req_if.sink     req_bus,
   cslp_rsp_if.source   rsp_bus,
   cslp_csr_if.sink     csr_bus
);

   localparam int POS_BITS  = $clog2(STORE_DEPTH);
   localparam int FILL_BITS = $clog2(STORE_DEPTH + 1);
   localparam logic [POS_BITS-1:0] POS_LAST = POS_BITS'(STORE_DEPTH - 1);

   // configuration registers
   logic [cslp_pkg::COUNT_BITS-1:0]   loop_length_ff;
   logic [cslp_pkg::TIMEOUT_BITS-1:0] timeout_ms_ff;

   // looper state
   logic [cslp_pkg::MODE_BITS-1:0]  mode_ff, mode_in;
   logic [cslp_pkg::COUNT_BITS-1:0] count_ff, count_in;
   logic [cslp_pkg::TIME_BITS-1:0]  last_time_ff, last_time_in;
   logic                            gate_prev_ff;
   logic [POS_BITS-1:0]             pos_ff, pos_in, pos_wr;
   logic [FILL_BITS-1:0]            fill_ff, fill_in, pos_wr_next;

   // store read stage
   logic                            s1_valid_ff, s1_valid_in;
   cslp_pkg::meta_type              s1_meta_ff, s1_meta_in;
   logic signed [SAMPLE_BITS-1:0]   s1_sample_ff;
   logic signed [SAMPLE_BITS-1:0]   rd_data_ff;
   logic signed [SAMPLE_BITS-1:0]   loop_store [STORE_DEPTH];

   logic                            out_ready, accept, rise, timed_out, wrap, wr_en;
   logic [cslp_pkg::TIME_BITS-1:0]  gap;
   logic [cslp_pkg::COUNT_BITS-1:0] count_a;
   logic [POS_BITS-1:0]             pos_a;

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = !s1_valid_ff || out_ready;
   assign accept        = req_bus.valid && req_bus.ready;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         loop_length_ff <= cslp_pkg::LOOP_LENGTH_RST;
         timeout_ms_ff  <= cslp_pkg::TIMEOUT_MS_RST;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            cslp_pkg::CSR_LOOP_LENGTH: loop_length_ff <= csr_bus.data[cslp_pkg::COUNT_BITS-1:0];
            cslp_pkg::CSR_TIMEOUT_MS:  timeout_ms_ff  <= csr_bus.data;
            default: ;
         endcase
      end
   end

   // pulse count, timeout and mode advance for one frame
   always_comb begin
      rise      = req_bus.gate && !gate_prev_ff;
      gap       = req_bus.time_ms - last_time_ff;
      timed_out = gap > {{(cslp_pkg::TIME_BITS-cslp_pkg::TIMEOUT_BITS){1'b0}}, timeout_ms_ff};
      count_a   = timed_out ? '0 : count_ff + 1'b1;
      pos_a     = timed_out ? '0 : pos_ff;
      wrap      = count_a >= loop_length_ff;

      mode_in      = mode_ff;
      count_in     = count_ff;
      pos_wr       = pos_ff;
      last_time_in = last_time_ff;
      if (rise) begin
         last_time_in = req_bus.time_ms;
         count_in     = wrap ? '0 : count_a;
         pos_wr       = wrap ? '0 : pos_a;
         if (wrap) begin
            case (mode_ff)
               cslp_pkg::MODE_ARMED:  mode_in = cslp_pkg::MODE_RECORD;
               cslp_pkg::MODE_RECORD: mode_in = cslp_pkg::MODE_PLAY;
               default:               mode_in = mode_ff;
            endcase
         end
      end
      if (req_bus.arm) begin
         mode_in = cslp_pkg::MODE_ARMED;
      end

      // record at the current position, play from the next one
      wr_en       = accept && (mode_in == cslp_pkg::MODE_RECORD);
      pos_in      = (pos_wr == POS_LAST) ? '0 : pos_wr + 1'b1;
      pos_wr_next = FILL_BITS'(pos_wr) + 1'b1;
      fill_in     = (wr_en && (pos_wr_next > fill_ff)) ? pos_wr_next : fill_ff;

      s1_meta_in.use_store = (mode_in == cslp_pkg::MODE_PLAY) &&
                             (FILL_BITS'(pos_in) < fill_ff);
      s1_meta_in.mode      = mode_in;
      s1_meta_in.count     = count_in;
   end

   // looper state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= cslp_pkg::MODE_IDLE;
         count_ff     <= '0;
         last_time_ff <= '0;
         gate_prev_ff <= 1'b0;
         pos_ff       <= '0;
         fill_ff      <= '0;
      end else if (accept) begin
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         last_time_ff <= last_time_in;
         gate_prev_ff <= req_bus.gate;
         pos_ff       <= pos_in;
         fill_ff      <= fill_in;
      end
   end

   // loop store: write while recording, registered read of the next position
   always_ff @(posedge clock) begin
      if (wr_en) begin
         loop_store[pos_wr] <= req_bus.sample_in;
      end
      if (accept) begin
         rd_data_ff <= loop_store[pos_in];
      end
   end

   // store read stage valid
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (out_ready) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_meta_ff   <= s1_meta_in;
         s1_sample_ff <= req_bus.sample_in;
      end
   end

   cslp_out_stage #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .in_ready  (out_ready),
      .in_meta   (s1_meta_ff),
      .in_sample (s1_sample_ff),
      .in_stored (rd_data_ff),
      .rsp       (rsp_bus)
   );

endmodule

@@ sim/clock_synced_audio_looper_top_test.sv @@
`timescale 1ns / 1ps
// clock_synced_audio_looper_top_test: self-checking bench for the clock-synced audio looper
// depends on cslp_pkg, the cslp channel interfaces and clock_synced_audio_looper_top

module clock_synced_audio_looper_top_test;

   localparam int HALF_PERIOD    = 5;
   localparam int RESET_CYCLES   = 8;
   localparam int TB_STORE_DEPTH = 1024;
   localparam int TB_POS_BITS    = $clog2(TB_STORE_DEPTH);
   localparam int SB             = cslp_pkg::SAMPLE_BITS_DEF;
   localparam int DATA_BITS      = cslp_pkg::CSR_DATA_BITS;
   localparam int IDLE_LIMIT     = 5000;
   localparam int LONG_HOLD      = 300;
   localparam int SETTLE_CYCLES  = 4;
   localparam int RECORD_WORDS   = 30;

   localparam logic signed [SB-1:0] SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
   localparam logic signed [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};

   // register indexes with no register behind them
   localparam logic [cslp_pkg::CSR_IDX_BITS-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [cslp_pkg::CSR_IDX_BITS-1:0] CSR_SPARE_3 = 2'd3;

   // receiver ready patterns
   localparam int SINK_OPEN    = 0;
   localparam int SINK_RANDOM  = 1;
   localparam int SINK_PATTERN = 2;
   localparam int SINK_SPARSE  = 3;

   typedef struct {
      logic                             gate;
      logic                             arm;
      logic [cslp_pkg::TIME_BITS-1:0]   time_ms;
      logic signed [SB-1:0]             sample;
   } frame_type;

   typedef struct {
      logic signed [SB-1:0]             sample_out;
      logic [cslp_pkg::MODE_BITS-1:0]   loop_mode;
      logic [cslp_pkg::COUNT_BITS-1:0]  pulse_number;
   } mix_result_type;

   logic clock = 1'b0;
   logic reset;

   cslp_req_if req ();
   cslp_rsp_if rsp ();
   cslp_csr_if csr ();

   clock_synced_audio_looper_top #(
      .STORE_DEPTH(TB_STORE_DEPTH)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req),
      .rsp_bus (rsp),
      .csr_bus (csr)
   );

   // predicted looper state and registers
   logic [cslp_pkg::COUNT_BITS-1:0]   m_loop_len;
   logic [cslp_pkg::TIMEOUT_BITS-1:0] m_timeout;
   logic [cslp_pkg::MODE_BITS-1:0]    m_mode;
   logic [cslp_pkg::COUNT_BITS-1:0]   m_count;
   logic [cslp_pkg::TIME_BITS-1:0]    m_last_pulse;
   logic                              m_gate_prev;
   logic [TB_POS_BITS-1:0]            m_pos;
   logic signed [SB-1:0]              m_loop_mem [TB_STORE_DEPTH];

   // results still owed by the block, oldest first
   mix_result_type results_due [$];

   // stimulus generator state
   logic [cslp_pkg::TIME_BITS-1:0] gen_time;
   logic                           gen_gate;
   int                             gen_level_left;
   int                             burst_left;
   bit                             sender_gaps;

   // receiver control
   int sink_style;
   int sink_cycle;
   int stall_request;
   int stall_left;

   // bookkeeping
   int err_count;
   int idle_cycles;
   int n_frames;
   int n_checked;
   int n_writes;
   int n_play;
   int n_sat;
   int n_advance;
   int n_timeouts;

   always #HALF_PERIOD clock = ~clock;

   // one frame through the looper: pulse count, mode, store and mix
   function automatic mix_result_type mix_frame(input frame_type f);
      logic [cslp_pkg::TIME_BITS-1:0] gap;
      logic signed [SB:0]             wide;
      mix_result_type                 r;
      if (f.gate && !m_gate_prev) begin
         gap = f.time_ms - m_last_pulse;
         m_last_pulse = f.time_ms;
         m_count = m_count + 1'b1;
         if (gap > m_timeout) begin
            m_count = '0;
            m_pos = '0;
            n_timeouts++;
         end
         if (m_count >= m_loop_len) begin
            m_count = '0;
            m_pos = '0;
            if (m_mode == cslp_pkg::MODE_ARMED) begin
               m_mode = cslp_pkg::MODE_RECORD;
               n_advance++;
            end else if (m_mode == cslp_pkg::MODE_RECORD) begin
               m_mode = cslp_pkg::MODE_PLAY;
               n_advance++;
            end
         end
      end
      if (f.arm)
         m_mode = cslp_pkg::MODE_ARMED;
      m_gate_prev = f.gate;

      if (m_mode == cslp_pkg::MODE_RECORD)
         m_loop_mem[m_pos] = f.sample;
      m_pos = (m_pos == TB_POS_BITS'(TB_STORE_DEPTH - 1)) ? '0 : m_pos + 1'b1;

      r.sample_out = f.sample;
      if (m_mode == cslp_pkg::MODE_PLAY) begin
         n_play++;
         wide = f.sample + m_loop_mem[m_pos];
         if (wide > SAMPLE_MAX) begin
            r.sample_out = SAMPLE_MAX;
            n_sat++;
         end else if (wide < SAMPLE_MIN) begin
            r.sample_out = SAMPLE_MIN;
            n_sat++;
         end else begin
            r.sample_out = wide[SB-1:0];
         end
      end
      r.loop_mode = m_mode;
      r.pulse_number = m_count;
      return r;
   endfunction

   function automatic frame_type frame_of(input logic g, input logic a,
                                          input logic [cslp_pkg::TIME_BITS-1:0] t,
                                          input logic signed [SB-1:0] s);
      frame_type f;
      f.gate = g;
      f.arm = a;
      f.time_ms = t;
      f.sample = s;
      return f;
   endfunction

   // full scale often enough to hit saturation in playback
   function automatic logic signed [SB-1:0] pick_sample();
      logic signed [SB-1:0] s;
      case ($urandom_range(0, 9))
         0: begin
            s = SAMPLE_MAX;
         end
         1: begin
            s = SAMPLE_MIN;
         end
         default: begin
            s = SB'($urandom);
         end
      endcase
      return s;
   endfunction

   // mostly a steady gate clock with small time steps, some noise and timeouts
   function automatic frame_type next_groove_frame();
      frame_type f;
      int        roll;
      roll = $urandom_range(0, 99);
      f.sample = pick_sample();
      if (roll < 5) begin
         f.gate = 1'($urandom_range(0, 1));
         f.arm = ($urandom_range(0, 7) == 0);
         f.time_ms = $urandom;
         gen_time = f.time_ms;
         gen_gate = f.gate;
         return f;
      end
      if (gen_level_left <= 0) begin
         gen_gate = !gen_gate;
         gen_level_left = $urandom_range(1, 4);
      end
      gen_level_left--;
      if (roll < 8)
         gen_time = gen_time + m_timeout + $urandom_range(1, 40);
      else
         gen_time = gen_time + $urandom_range(0, 3);
      f.gate = gen_gate;
      f.time_ms = gen_time;
      if (m_mode == cslp_pkg::MODE_IDLE)
         f.arm = ($urandom_range(0, 2) == 0);
      else if (m_mode == cslp_pkg::MODE_PLAY)
         f.arm = ($urandom_range(0, 119) == 0);
      else
         f.arm = ($urandom_range(0, 299) == 0);
      return f;
   endfunction

   task automatic flag_result(input string field, input longint want, input longint got);
      err_count++;
      $display("%0t: %s mismatch, expected %0d got %0d", $time, field, want, got);
   endtask

   // sender: bursts of words with random gaps between them when sender_gaps is set
   task automatic send_frame(input frame_type f);
      int gap;
      if (burst_left <= 0) begin
         gap = sender_gaps ? $urandom_range(0, 7) : 0;
         if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      req.valid <= 1'b1;
      req.gate <= f.gate;
      req.arm <= f.arm;
      req.time_ms <= f.time_ms;
      req.sample_in <= f.sample;
      do @(posedge clock); while (req.ready !== 1'b1);
      results_due.push_back(mix_frame(f));
      burst_left--;
      n_frames++;
   endtask

   // stop offering and wait until every owed result has come out
   task automatic settle_block();
      req.valid <= 1'b0;
      burst_left = 0;
      while (results_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [cslp_pkg::CSR_IDX_BITS-1:0] idx,
                            input logic [DATA_BITS-1:0] value);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data <= value;
      do @(posedge clock); while (csr.ready !== 1'b1);
      csr.valid <= 1'b0;
      n_writes++;
      if (idx == cslp_pkg::CSR_LOOP_LENGTH)
         m_loop_len = value[cslp_pkg::COUNT_BITS-1:0];
      else if (idx == cslp_pkg::CSR_TIMEOUT_MS)
         m_timeout = value;
      @(posedge clock);
   endtask

   // reset values, gaps just past the timeout, first pulse from time zero
   task automatic test_default_registers();
      sink_style = SINK_RANDOM;
      sender_gaps = 1'b1;
      send_frame(frame_of(1'b1, 1'b0, 32'd500, SAMPLE_MAX));
      send_frame(frame_of(1'b0, 1'b0, 32'd501, SAMPLE_MIN));
      send_frame(frame_of(1'b1, 1'b0, 32'd1502, 24'sd1));
      send_frame(frame_of(1'b0, 1'b0, 32'd1503, '0));
      send_frame(frame_of(1'b1, 1'b0, 32'd2503, -24'sd1));
   endtask

   // zero loop length: every pulse advances; idle stays idle, arm beats the advance
   task automatic test_zero_length_and_arm();
      settle_block();
      write_reg(cslp_pkg::CSR_LOOP_LENGTH, 16'hFFC0);
      write_reg(CSR_SPARE_2, 16'h0003);
      write_reg(CSR_SPARE_3, 16'hFFFF);
      sink_style = SINK_PATTERN;
      send_frame(frame_of(1'b0, 1'b0, 32'd2504, 24'sd5));
      send_frame(frame_of(1'b1, 1'b0, 32'd2505, 24'sd6));
      send_frame(frame_of(1'b0, 1'b1, 32'd2506, 24'sd7));
      send_frame(frame_of(1'b1, 1'b1, 32'd2507, 24'sd8));
      send_frame(frame_of(1'b0, 1'b0, 32'd2508, 24'sd9));
      // recording: full scale words so playback saturates both ways
      send_frame(frame_of(1'b1, 1'b0, 32'd2509, SAMPLE_MAX));
      send_frame(frame_of(1'b0, 1'b0, 32'd2510, SAMPLE_MIN));
      send_frame(frame_of(1'b0, 1'b0, 32'd2510, SAMPLE_MAX));
      send_frame(frame_of(1'b1, 1'b0, 32'd2511, SAMPLE_MIN));
      send_frame(frame_of(1'b0, 1'b0, 32'd2512, SAMPLE_MAX));
      send_frame(frame_of(1'b0, 1'b0, 32'd2512, 24'sd1));
      // a pulse in playback leaves the mode alone
      send_frame(frame_of(1'b1, 1'b0, 32'd2513, -24'sd3));
   endtask

   // count built up under a length of 40, then the length lowered to the count
   task automatic test_length_lowered();
      settle_block();
      write_reg(cslp_pkg::CSR_LOOP_LENGTH, 16'd40);
      sink_style = SINK_SPARSE;
      send_frame(frame_of(1'b0, 1'b1, 32'hFFFF_FFE0, 24'sd11));
      send_frame(frame_of(1'b1, 1'b0, 32'hFFFF_FFF0, 24'sd12));
      send_frame(frame_of(1'b0, 1'b0, 32'hFFFF_FFF2, 24'sd13));
      send_frame(frame_of(1'b1, 1'b0, 32'hFFFF_FFF4, 24'sd14));
      send_frame(frame_of(1'b0, 1'b0, 32'hFFFF_FFFA, 24'sd15));
      // time wraps between these two pulses
      send_frame(frame_of(1'b1, 1'b0, 32'h0000_0002, 24'sd16));
      settle_block();
      write_reg(cslp_pkg::CSR_LOOP_LENGTH, 16'd2);
      send_frame(frame_of(1'b0, 1'b0, 32'h0000_0003, 24'sd17));
      send_frame(frame_of(1'b1, 1'b0, 32'h0000_0004, 24'sd18));
   endtask

   // receiver holds off while the sender keeps offering, then a full drain
   task automatic test_output_backpressure();
      settle_block();
      write_reg(cslp_pkg::CSR_LOOP_LENGTH, 16'd3);
      write_reg(cslp_pkg::CSR_TIMEOUT_MS, 16'd1000);
      sink_style = SINK_OPEN;
      sender_gaps = 1'b0;
      stall_request = LONG_HOLD;
      repeat (60) send_frame(next_groove_frame());
      settle_block();
   endtask

   task automatic run_groove_phase(input logic [cslp_pkg::COUNT_BITS-1:0] len,
                                   input logic [cslp_pkg::TIMEOUT_BITS-1:0] tmo,
                                   input int style, input bit gaps, input int count);
      logic [DATA_BITS-1:0] len_word;
      settle_block();
      len_word = DATA_BITS'($urandom);
      len_word[cslp_pkg::COUNT_BITS-1:0] = len;
      write_reg(cslp_pkg::CSR_LOOP_LENGTH, len_word);
      write_reg(cslp_pkg::CSR_TIMEOUT_MS, tmo);
      sink_style = style;
      sender_gaps = gaps;
      repeat (count) send_frame(next_groove_frame());
   endtask

   // random loops across several register settings, extremes included
   task automatic test_groove_phases();
      run_groove_phase(6'd3, 16'd1000, SINK_RANDOM, 1'b1, 100);
      run_groove_phase(6'd0, 16'd65535, SINK_PATTERN, 1'b1, 80);
      run_groove_phase(6'd1, 16'd1, SINK_OPEN, 1'b0, 60);
      run_groove_phase(6'd2, 16'd0, SINK_RANDOM, 1'b1, 50);
      run_groove_phase(6'd33, 16'd40, SINK_SPARSE, 1'b1, 130);
      run_groove_phase(6'd63, 16'd300, SINK_PATTERN, 1'b1, 50);
      run_groove_phase(6'd4, 16'd500, SINK_RANDOM, 1'b1, 80);
   endtask

   // one-pulse loop: record a stretch of words, then play over the recorded stretch
   task automatic test_record_playback();
      settle_block();
      write_reg(cslp_pkg::CSR_LOOP_LENGTH, 16'd1);
      write_reg(cslp_pkg::CSR_TIMEOUT_MS, 16'd65535);
      sink_style = SINK_RANDOM;
      sender_gaps = 1'b1;
      send_frame(frame_of(1'b0, 1'b1, m_last_pulse, pick_sample()));
      send_frame(frame_of(1'b1, 1'b0, m_last_pulse, pick_sample()));
      repeat (RECORD_WORDS)
         send_frame(frame_of(1'b0, 1'b0, m_last_pulse, pick_sample()));
      send_frame(frame_of(1'b1, 1'b0, m_last_pulse, pick_sample()));
      repeat (RECORD_WORDS)
         send_frame(frame_of(1'b0, 1'b0, m_last_pulse, pick_sample()));
   endtask

   // receiver ready, with an optional long hold counted here
   always @(posedge clock) begin
      sink_cycle++;
      if (stall_request > 0) begin
         stall_left = stall_request;
         stall_request = 0;
      end
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp.ready <= 1'b0;
         stall_left--;
      end else begin
         case (sink_style)
            SINK_OPEN: begin
               rsp.ready <= 1'b1;
            end
            SINK_RANDOM: begin
               rsp.ready <= ($urandom_range(0, 3) != 0);
            end
            SINK_PATTERN: begin
               rsp.ready <= ((sink_cycle % 11) >= 3);
            end
            default: begin
               rsp.ready <= ($urandom_range(0, 9) < 3);
            end
         endcase
      end
   end

   // compare each result word with the oldest prediction
   always @(posedge clock) begin : check_results
      mix_result_type want;
      if (!reset && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
         n_checked++;
         if (results_due.size() == 0) begin
            flag_result("result with no word pending", 0, rsp.sample_out);
         end else begin
            want = results_due.pop_front();
            if (rsp.sample_out !== want.sample_out)
               flag_result("sample_out", want.sample_out, rsp.sample_out);
            if (rsp.loop_mode !== want.loop_mode)
               flag_result("loop_mode", want.loop_mode, rsp.loop_mode);
            if (rsp.pulse_number !== want.pulse_number)
               flag_result("pulse_number", want.pulse_number, rsp.pulse_number);
         end
      end
   end

   // watchdog on cycles with no handshake anywhere
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (csr.valid && csr.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d results owed",
                  idle_cycles, results_due.size());
         $display("clock_synced_audio_looper_top verification failed");
         $finish;
      end
   end

   initial begin
      reset <= 1'b1;
      req.valid <= 1'b0;
      req.gate <= 1'b0;
      req.arm <= 1'b0;
      req.time_ms <= '0;
      req.sample_in <= '0;
      csr.valid <= 1'b0;
      csr.index <= '0;
      csr.data <= '0;

      m_loop_len = cslp_pkg::LOOP_LENGTH_RST;
      m_timeout = cslp_pkg::TIMEOUT_MS_RST;
      m_mode = cslp_pkg::MODE_IDLE;
      m_count = '0;
      m_last_pulse = '0;
      m_gate_prev = 1'b0;
      m_pos = '0;
      foreach (m_loop_mem[i])
         m_loop_mem[i] = '0;

      gen_time = $urandom;
      gen_gate = 1'b0;
      gen_level_left = 0;
      burst_left = 0;
      sender_gaps = 1'b1;
      sink_style = SINK_OPEN;
      sink_cycle = 0;
      stall_request = 0;
      stall_left = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_default_registers();
      test_zero_length_and_arm();
      test_length_lowered();
      test_output_backpressure();
      test_groove_phases();
      test_record_playback();
      settle_block();

      $display("ran %0d words and %0d register writes, %0d results checked",
               n_frames, n_writes, n_checked);
      $display("%0d playback words (%0d saturated), %0d mode advances, %0d timeout clears",
               n_play, n_sat, n_advance, n_timeouts);
      if (err_count == 0 && results_due.size() == 0)
         $display("clock_synced_audio_looper_top verification clean");
      else
         $display("clock_synced_audio_looper_top verification failed");
      $finish;
   end

endmodule
